// ----- hw/rtl/weighted_index_sample_assert.svh -----
// Assertion macros shared by the weighted index sampler RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef WEIGHTED_INDEX_SAMPLE_ASSERT_SVH
`define WEIGHTED_INDEX_SAMPLE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define WIS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("weighted_index_sample: check failed");

// next-cycle implication, disabled during reset
`define WIS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("weighted_index_sample: check failed");

`endif

// ----- hw/rtl/wis_pkg.sv -----
// Package for the weighted index sampler: widths, defaults, request codes,
// and the command/status structs between controller and datapath.
package wis_pkg;

  // default configuration
  localparam int WIS_DEPTH         = 1024;
  localparam int WIS_WEIGHT_BITS   = 32;
  localparam int WIS_FRACTION_BITS = 16;

  // fixed port field widths
  localparam int ENTRY_W   = 10;
  localparam int WVAL_W    = 32;
  localparam int UVAL_W    = 16;
  localparam int START_W   = 10;
  localparam int IDX_W     = 11;

  // multiplier slicing: one 32x32 multiplier used twice
  localparam int MUL_W  = 32;
  localparam int PP_W   = 2 * MUL_W;
  localparam int SPAN_W = 2 * MUL_W;
  localparam int PROD_W = 3 * MUL_W;

  // request codes
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // table address source
  typedef enum logic [2:0] {
    ADDR_ENTRY,
    ADDR_LOW,
    ADDR_HIGH,
    ADDR_START,
    ADDR_NEXT
  } addr_sel_e;

  typedef struct packed {
    logic      wr_en;
    logic      cap_req;
    addr_sel_e addr_sel;
    logic      ld_wmin;
    logic      ld_span;
    logic      mul_lo;
    logic      mul_hi;
    logic      ld_s;
    logic      j_init;
    logic      j_inc;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic is_sample;
    logic req_err;
    logic load_ok;
    logic hit;
    logic at_end;
  } sts_t;

endpackage

// ----- hw/rtl/wis_req_if.sv -----
// Request channel of the weighted index sampler: valid/ready plus one word.
// Depends on wis_pkg for field widths.
interface wis_req_if;
  import wis_pkg::*;

  logic               valid;
  logic               ready;
  logic               req_type;
  logic [ENTRY_W-1:0] entry_index;
  logic [WVAL_W-1:0]  weight_value;
  logic [UVAL_W-1:0]  uniform_value;
  logic [START_W-1:0] range_start;
  logic [IDX_W-1:0]   range_end;

  modport source (
    output valid, req_type, entry_index, weight_value, uniform_value,
           range_start, range_end,
    input  ready
  );

  modport sink (
    input  valid, req_type, entry_index, weight_value, uniform_value,
           range_start, range_end,
    output ready
  );
endinterface

// ----- hw/rtl/wis_res_if.sv -----
// Result channel of the weighted index sampler: valid/ready plus one word.
// Depends on wis_pkg for field widths.
interface wis_res_if;
  import wis_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] sample_index;
  logic             range_error;

  modport source (
    output valid, sample_index, range_error,
    input  ready
  );

  modport sink (
    input  valid, sample_index, range_error,
    output ready
  );
endinterface

// ----- hw/rtl/wis_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
module wis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/wis_datapath.sv -----
// Datapath of the weighted index sampler: weight table, span scaling and scan.
// Depends on wis_pkg and wis_ram.
module wis_datapath #(
  parameter int DEPTH         = wis_pkg::WIS_DEPTH,
  parameter int WEIGHT_BITS   = wis_pkg::WIS_WEIGHT_BITS,
  parameter int FRACTION_BITS = wis_pkg::WIS_FRACTION_BITS
) (
  input  logic                         clk_i,
  input  wis_pkg::cmd_t                cmd_i,
  output wis_pkg::sts_t                sts_o,
  input  logic                         req_type_i,
  input  logic [wis_pkg::ENTRY_W-1:0]  entry_index_i,
  input  logic [wis_pkg::WVAL_W-1:0]   weight_value_i,
  input  logic [wis_pkg::UVAL_W-1:0]   uniform_value_i,
  input  logic [wis_pkg::START_W-1:0]  range_start_i,
  input  logic [wis_pkg::IDX_W-1:0]    range_end_i,
  output logic [wis_pkg::IDX_W-1:0]    sample_index_o,
  output logic                         range_error_o
);
  import wis_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [START_W-1:0]       start_q;
  logic [IDX_W-1:0]         end_q;
  logic [FRACTION_BITS-1:0] u_q;
  logic                     err_q;
  logic [WEIGHT_BITS-1:0]   wmin_q, span_q, s_q;
  logic [PP_W-1:0]          plo_q, phi_q;
  logic [IDX_W-1:0]         j_q;
  logic [IDX_W-1:0]         res_idx_q;
  logic                     res_err_q;

  logic [AW-1:0]          ram_addr;
  logic [WEIGHT_BITS-1:0] ram_rdata;
  logic [MUL_W-1:0]       u_ext;
  logic [SPAN_W-1:0]      span_ext;
  logic [PROD_W-1:0]      prod_full;
  logic [WEIGHT_BITS-1:0] scaled;

  // live request decode, used on the accept cycle
  assign sts_o.is_sample = (req_type_i == REQ_SAMPLE);
  assign sts_o.req_err   = (range_end_i <= IDX_W'(range_start_i)) ||
                           (32'(range_end_i) > 32'(DEPTH));
  assign sts_o.load_ok   = (32'(entry_index_i) < 32'(DEPTH));

  // scan status: rdata holds table[j]
  assign sts_o.hit    = (s_q < ram_rdata);
  assign sts_o.at_end = ((j_q + IDX_W'(1)) == end_q);

  // table address select
  always_comb begin
    unique case (cmd_i.addr_sel)
      ADDR_ENTRY: ram_addr = AW'(entry_index_i);
      ADDR_LOW:   ram_addr = AW'(start_q) - AW'(1);
      ADDR_HIGH:  ram_addr = AW'(end_q - IDX_W'(1));
      ADDR_START: ram_addr = AW'(start_q);
      ADDR_NEXT:  ram_addr = AW'(j_q + IDX_W'(1));
      default:    ram_addr = AW'(entry_index_i);
    endcase
  end

  wis_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .addr_i  (ram_addr),
    .wdata_i (WEIGHT_BITS'(weight_value_i)),
    .rdata_o (ram_rdata)
  );

  // operands for the shared 32x32 multiplier
  assign u_ext    = MUL_W'(u_q);
  assign span_ext = SPAN_W'(span_q);

  // recombine partial products, drop fraction bits, add lower weight
  assign prod_full = {phi_q[MUL_W*2-1:0], {MUL_W{1'b0}}} + PROD_W'(plo_q);
  assign scaled    = WEIGHT_BITS'(prod_full >> FRACTION_BITS);

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_req) begin
      start_q <= range_start_i;
      end_q   <= range_end_i;
      u_q     <= FRACTION_BITS'(uniform_value_i);
      err_q   <= sts_o.req_err;
    end
    if (cmd_i.ld_wmin) begin
      wmin_q <= (start_q == '0) ? '0 : ram_rdata;
    end
    if (cmd_i.ld_span) begin
      span_q <= ram_rdata - wmin_q;
    end
    if (cmd_i.mul_lo) begin
      plo_q <= PP_W'(u_ext) * PP_W'(span_ext[MUL_W-1:0]);
    end
    if (cmd_i.mul_hi) begin
      phi_q <= PP_W'(u_ext) * PP_W'(span_ext[SPAN_W-1:MUL_W]);
    end
    if (cmd_i.ld_s) begin
      s_q <= wmin_q + scaled;
    end
    if (cmd_i.j_init) begin
      j_q <= IDX_W'(start_q);
    end else if (cmd_i.j_inc) begin
      j_q <= j_q + IDX_W'(1);
    end
    if (cmd_i.out_load) begin
      res_idx_q <= err_q ? '0 : j_q;
      res_err_q <= err_q;
    end
  end

  assign sample_index_o = res_idx_q;
  assign range_error_o  = res_err_q;

endmodule

// ----- hw/rtl/wis_ctrl.sv -----
// Controller of the weighted index sampler: gates table writes for load words, sequences boundary reads,
// the two multiply passes, the scan, and the output register handshake.
// Depends on wis_pkg and weighted_index_sample_assert.svh.
`include "weighted_index_sample_assert.svh"

module wis_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  input  wis_pkg::sts_t sts_i,
  output wis_pkg::cmd_t cmd_o
);
  import wis_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDLO  = 4'd1;
  localparam logic [3:0] S_RDHI  = 4'd2;
  localparam logic [3:0] S_SPAN  = 4'd3;
  localparam logic [3:0] S_MULLO = 4'd4;
  localparam logic [3:0] S_MULHI = 4'd5;
  localparam logic [3:0] S_SUM   = 4'd6;
  localparam logic [3:0] S_SCAN  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign req_ready_o = (state_q == S_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign res_valid_o = out_valid_q;

  // next state and datapath commands
  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    cmd_o.addr_sel = ADDR_ENTRY;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.cap_req = 1'b1;
          if (!sts_i.is_sample) begin
            cmd_o.wr_en = sts_i.load_ok;
          end else if (sts_i.req_err) begin
            state_d = S_OUT;
          end else begin
            state_d = S_RDLO;
          end
        end
      end
      S_RDLO: begin
        cmd_o.addr_sel = ADDR_LOW;
        state_d        = S_RDHI;
      end
      S_RDHI: begin
        cmd_o.addr_sel = ADDR_HIGH;
        cmd_o.ld_wmin  = 1'b1;
        state_d        = S_SPAN;
      end
      S_SPAN: begin
        cmd_o.ld_span = 1'b1;
        state_d       = S_MULLO;
      end
      S_MULLO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = S_MULHI;
      end
      S_MULHI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = S_SUM;
      end
      S_SUM: begin
        cmd_o.ld_s     = 1'b1;
        cmd_o.addr_sel = ADDR_START;
        cmd_o.j_init   = 1'b1;
        state_d        = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.addr_sel = ADDR_NEXT;
        if (sts_i.hit) begin
          state_d = S_OUT;
        end else begin
          // past the last entry j lands on the range end
          cmd_o.j_inc = 1'b1;
          if (sts_i.at_end) begin
            state_d = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_q || res_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output word valid flag
  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output register is only overwritten when empty or being drained
  `WIS_ASSERT_NOW(a_out_load_free, cmd_o.out_load, !out_valid_q || res_ready_i)
  // a loaded result is presented next cycle with the controller back idle
  `WIS_ASSERT_NEXT(a_out_load_shows, cmd_o.out_load, out_valid_q && state_q == S_IDLE)
  // a good sample request starts with the lower boundary read
  `WIS_ASSERT_NEXT(a_sample_start, accept && sts_i.is_sample && !sts_i.req_err,
                   state_q == S_RDLO)
  // table writes happen only on accepted load words
  `WIS_ASSERT_NOW(a_write_on_load, cmd_o.wr_en, accept && !sts_i.is_sample)

endmodule

// ----- hw/rtl/weighted_index_sample.sv -----
// Top level of the weighted index sampler: inverse-CDF index selection over
// a loaded table of cumulative weights. Depends on wis_pkg, wis_req_if,
// wis_res_if, wis_ram, wis_datapath and wis_ctrl.
//
//   channel | dir | word
//   --------+-----+--------------------------------------------------------
//   req_i   | in  | req_type, entry_index, weight_value, uniform_value,
//           |     | range_start, range_end
//   res_o   | out | sample_index, range_error (one per sample request)
//
// A load word is written on its accept cycle. A sample with a bad range goes
// straight to the output state. A good sample scans from range_start up to
// sample_index, at most to the range end: the scan reads one table entry
// per cycle through the single RAM port after two boundary reads and two
// 32x32 multiply passes. Reset is asynchronous, active low; the weight table
// is not cleared. One request is in flight at a time; the finished word
// waits in the output register while the next request is accepted.
module weighted_index_sample #(
  parameter int DEPTH         = wis_pkg::WIS_DEPTH,
  parameter int WEIGHT_BITS   = wis_pkg::WIS_WEIGHT_BITS,
  parameter int FRACTION_BITS = wis_pkg::WIS_FRACTION_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wis_req_if.sink    req_i,
  wis_res_if.source  res_o
);
  import wis_pkg::*;

  cmd_t cmd;
  sts_t sts;

  wis_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  wis_datapath #(
    .DEPTH         (DEPTH),
    .WEIGHT_BITS   (WEIGHT_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req_type_i      (req_i.req_type),
    .entry_index_i   (req_i.entry_index),
    .weight_value_i  (req_i.weight_value),
    .uniform_value_i (req_i.uniform_value),
    .range_start_i   (req_i.range_start),
    .range_end_i     (req_i.range_end),
    .sample_index_o  (res_o.sample_index),
    .range_error_o   (res_o.range_error)
  );

endmodule

// ----- sim/wis_pick_checker.sv -----
// Checker for the weighted index sampler: watches the request and result channels,
// predicts each sample pick from its own copy of the weight table, and compares.
// Depends on wis_pkg, wis_req_if and wis_res_if.
module wis_pick_checker (
  input  logic clk_i,
  input  logic rst_ni,
  wis_req_if   req_mon,
  wis_res_if   res_mon,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import wis_pkg::*;

  localparam int DEPTH = WIS_DEPTH;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             err;
  } pick_t;

  logic [WVAL_W-1:0] weight_tbl [DEPTH];
  pick_t             expected_picks [$];
  int                fail_cnt;

  assign fail_count_o = fail_cnt;
  assign pending_o    = expected_picks.size();

  // inverse-CDF pick: scale the fraction onto [wlo, whi], then first entry above it
  function automatic pick_t predict_pick(logic [UVAL_W-1:0] frac, logic [START_W-1:0] first,
                                         logic [IDX_W-1:0] stop);
    pick_t             p;
    int                lo_i;
    int                hi_i;
    int                j;
    logic [WVAL_W-1:0] wlo;
    logic [WVAL_W-1:0] whi;
    logic [WVAL_W-1:0] span;
    logic [WVAL_W-1:0] level;
    logic [47:0]       prod;
    lo_i    = int'(first);
    hi_i    = int'(stop);
    p.index = '0;
    p.err   = 1'b1;
    if (hi_i <= lo_i || hi_i > DEPTH) return p;
    wlo   = (lo_i == 0) ? '0 : weight_tbl[lo_i - 1];
    whi   = weight_tbl[hi_i - 1];
    span  = whi - wlo;  // wraps when the upper weight is below the lower one
    prod  = 48'(frac) * 48'(span);
    level = wlo + prod[47:16];
    j = lo_i;
    while (j < hi_i && !(level < weight_tbl[j])) j++;
    p.index = IDX_W'(j);
    p.err   = 1'b0;
    return p;
  endfunction

  // results are taken before requests: a word never leaves in the cycle it enters
  always @(posedge clk_i or negedge rst_ni) begin
    pick_t want;
    if (!rst_ni) begin
      expected_picks.delete();
      fail_cnt = 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (expected_picks.size() == 0) begin
          $display("%0t: result word with no request pending: index %0d, error %0b",
                   $time, res_mon.sample_index, res_mon.range_error);
          fail_cnt++;
        end else begin
          want = expected_picks.pop_front();
          if (res_mon.range_error !== want.err) begin
            $display("%0t: range_error mismatch: expected %0b, got %0b",
                     $time, want.err, res_mon.range_error);
            fail_cnt++;
          end
          // a range error reports index zero
          if (res_mon.sample_index !== want.index) begin
            $display("%0t: sample_index mismatch: expected %0d, got %0d",
                     $time, want.index, res_mon.sample_index);
            fail_cnt++;
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        if (req_mon.req_type == REQ_LOAD) begin
          weight_tbl[req_mon.entry_index] = req_mon.weight_value;
        end else begin
          expected_picks.push_back(predict_pick(req_mon.uniform_value, req_mon.range_start,
                                                req_mon.range_end));
        end
      end
    end
  end
endmodule

// ----- sim/tb.sv -----
// Testbench top for the weighted index sampler: clock, reset, load and sample
// words with random pacing, and the verdict. Depends on wis_pkg, wis_req_if,
// wis_res_if, weighted_index_sample and wis_pick_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wis_pkg::*;

  localparam int    DEPTH        = WIS_DEPTH;
  localparam int    CLK_PERIOD   = 4;
  localparam int    ITEM_TARGET  = 950;
  localparam int    DRAIN_CYCLES = 1100;  // longest scan covers all DEPTH entries
  localparam int    HOLD_CYCLES  = 400;
  localparam longint RUN_LIMIT_NS = 64'd20_000_000;

  logic clk_i = 1'b0;
  logic rst_ni;

  wis_req_if req_if ();
  wis_res_if res_if ();

  int fails;
  int pending;
  int sent;
  int src_gap_max  = 0;
  int sink_gap_max = 0;
  bit hold_off_req = 1'b0;
  bit loaded [DEPTH];

  weighted_index_sample dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  wis_pick_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_if),
    .res_mon      (res_if),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // one request word, after a random gap
  task automatic send_word(logic kind, logic [ENTRY_W-1:0] idx, logic [WVAL_W-1:0] w,
                           logic [UVAL_W-1:0] u, logic [START_W-1:0] st,
                           logic [IDX_W-1:0] en);
    int gap;
    gap = $urandom_range(src_gap_max, 0);
    repeat (gap) begin
      @(negedge clk_i);
      req_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    req_if.valid         <= 1'b1;
    req_if.req_type      <= kind;
    req_if.entry_index   <= idx;
    req_if.weight_value  <= w;
    req_if.uniform_value <= u;
    req_if.range_start   <= st;
    req_if.range_end     <= en;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    sent++;
  endtask

  task automatic load_weight(int idx, logic [WVAL_W-1:0] w);
    loaded[idx] = 1'b1;
    send_word(REQ_LOAD, ENTRY_W'(idx), w, UVAL_W'($urandom), START_W'($urandom),
              IDX_W'($urandom));
  endtask

  task automatic request_pick(logic [UVAL_W-1:0] u, int st, int en);
    send_word(REQ_SAMPLE, ENTRY_W'($urandom), $urandom, u, START_W'(st), IDX_W'(en));
  endtask

  // a good range may only touch loaded entries, the one below start included
  function automatic bit span_loaded(int st, int en);
    int lo;
    lo = (st == 0) ? 0 : st - 1;
    for (int k = lo; k < en; k++) if (!loaded[k]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [UVAL_W-1:0] pick_fraction();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return UVAL_W'($urandom);
    endcase
  endfunction

  // cumulative weights over [base, base+len), ascending unless scrambled
  task automatic load_region(int base, int len, bit scrambled);
    logic [WVAL_W-1:0] level;
    logic [WVAL_W-1:0] step_max;
    case ($urandom_range(0, 2))
      0:       level = '0;
      1:       level = $urandom_range(1000, 0);
      default: level = $urandom;
    endcase
    step_max = (32'hFFFF_FFFF - level) / len;
    if ($urandom_range(0, 2) == 0 && step_max > 64) step_max = 64;  // many equal weights
    for (int k = 0; k < len; k++) begin
      if (scrambled) begin
        load_weight(base + k, $urandom);
      end else begin
        level = level + $urandom_range(step_max, 0);
        load_weight(base + k, level);
      end
    end
  endtask

  task automatic random_query(int base, int len);
    int          st;
    int          en;
    logic [UVAL_W-1:0] u;
    u = pick_fraction();
    case ($urandom_range(0, 9))
      0: begin
        st = $urandom_range(DEPTH - 1, 0);
        if ($urandom_range(0, 1) == 0) en = $urandom_range(st, 0);
        else en = $urandom_range(2047, DEPTH + 1);
      end
      1: begin
        st = $urandom_range(DEPTH - 1, 0);
        en = $urandom_range(DEPTH, st + 1);
      end
      default: begin
        st = $urandom_range(base + len - 1, base);
        en = $urandom_range(base + len, st + 1);
      end
    endcase
    // a good range over unloaded entries turns into an empty one
    if (en > st && en <= DEPTH && !span_loaded(st, en)) en = st;
    request_pick(u, st, en);
  endtask

  // result side: random hold-off per word, plus one long stall on request
  initial begin
    int wait_cycles;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        wait_cycles  = HOLD_CYCLES;
      end else begin
        wait_cycles = $urandom_range(sink_gap_max, 0);
      end
      repeat (wait_cycles) begin
        @(negedge clk_i);
        res_if.ready <= 1'b0;
      end
      @(negedge clk_i);
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_if.valid && res_if.ready));
    end
  end

  // stimulus and verdict
  initial begin
    int phase;
    int len;
    int base;
    int nq;
    sent                 = 0;
    rst_ni               = 1'b0;
    req_if.valid         = 1'b0;
    req_if.req_type      = REQ_LOAD;
    req_if.entry_index   = '0;
    req_if.weight_value  = '0;
    req_if.uniform_value = '0;
    req_if.range_start   = '0;
    req_if.range_end     = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: field extremes, flat and wrapping spans, bad ranges
    load_weight(0, 32'd0);
    load_weight(1, 32'd100);
    load_weight(2, 32'd100);
    load_weight(3, 32'd5000);
    load_weight(4, 32'hFFFF_FFFF);
    load_weight(1021, 32'hFFFF_0000);
    load_weight(1022, 32'd12);
    load_weight(1023, 32'hFFFF_FFFF);
    request_pick(16'h0000, 0, 5);
    request_pick(16'hFFFF, 0, 5);
    request_pick(16'h8000, 1, 4);
    request_pick(16'hFFFF, 0, 1);
    request_pick(16'hFFFF, 1022, 1024);
    request_pick(16'h1234, 1022, 1023);  // upper weight below lower: span wraps
    request_pick(16'hFFFF, 1023, 1024);
    request_pick(16'h4000, 3, 3);        // empty range
    request_pick(16'h4000, 1023, 0);     // end below start
    request_pick(16'h4000, 0, 1025);     // end past the table
    request_pick(16'hFFFF, 5, 2047);

    // random phases: load a region, then sample inside and around it
    phase = 0;
    while (sent < ITEM_TARGET) begin
      src_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 12;
      sink_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
      if (phase == 3) hold_off_req = 1'b1;
      if ($urandom_range(0, 15) == 0) len = $urandom_range(160, 60);
      else len = $urandom_range(24, 1);
      base = $urandom_range(DEPTH - len, 0);
      load_region(base, len, $urandom_range(0, 9) == 0);
      nq = $urandom_range(10, 2);
      repeat (nq) random_query(base, len);
      if ($urandom_range(0, 3) == 0) load_weight($urandom_range(DEPTH - 1, 0), $urandom);
      // let the block drain completely now and then
      if (phase % 6 == 5) begin
        @(negedge clk_i);
        req_if.valid <= 1'b0;
        wait (pending == 0);
      end
      phase++;
    end

    @(negedge clk_i);
    req_if.valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
